@@ hdl/gshp_pkg.sv @@
`default_nettype none

package gshp_pkg;

    // configuration register widths and port geometry
    localparam int CFG_W       = 4;
    localparam int CFG_INDEX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_BITS = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] INDEX_BITS_RST   = 4'd12;
    localparam logic [CFG_W-1:0] HISTORY_BITS_RST = 4'd0;

    // default table index width
    localparam int DEF_MAX_INDEX_BITS = 12;

    // two-bit saturating counter codes
    localparam int CTR_W = 2;
    localparam logic [CTR_W-1:0] CTR_STRONG_NT   = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN  = 2'd2;
    localparam logic [CTR_W-1:0] CTR_STRONG_TKN  = 2'd3;

    // running totals
    localparam int COUNT_W = 32;

    // stream word widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

endpackage

`default_nettype wire

@@ hdl/gshp_index.sv @@
`default_nettype none

module gshp_index #(
    parameter int MAX_INDEX_BITS = gshp_pkg::DEF_MAX_INDEX_BITS
) (
    input  wire logic [gshp_pkg::CFG_W-1:0]  index_bits,
    input  wire logic [gshp_pkg::CFG_W-1:0]  history_bits,
    input  wire logic [MAX_INDEX_BITS-1:0]   address_bits,
    input  wire logic [MAX_INDEX_BITS-1:0]   history,
    input  wire logic                        taken,
    output logic      [MAX_INDEX_BITS-1:0]   table_index,
    output logic      [MAX_INDEX_BITS-1:0]   history_next
);
    import gshp_pkg::*;

    localparam int IDX_W = MAX_INDEX_BITS;
    localparam int IB_W  = $clog2(MAX_INDEX_BITS + 1);

    logic [IB_W-1:0]  ib;
    logic [IB_W-1:0]  hb;
    logic [IB_W-1:0]  shamt;
    logic [IDX_W-1:0] imask;
    logic [IDX_W-1:0] hmask;
    logic [IDX_W-1:0] hist;
    logic [IDX_W-1:0] hist_sh;

    // effective index width, clamped into 1..max
    always_comb
    begin
        if (index_bits == '0)
            ib = IB_W'(1);
        else if (index_bits > MAX_INDEX_BITS)
            ib = IB_W'(MAX_INDEX_BITS);
        else
            ib = IB_W'(index_bits);
    end

    // history length never exceeds the index width
    always_comb
    begin
        if (history_bits > ib)
            hb = ib;
        else
            hb = IB_W'(history_bits);
    end

    assign imask   = ~({IDX_W{1'b1}} << ib);
    assign hmask   = ~({IDX_W{1'b1}} << hb);
    assign hist    = history & hmask;
    assign shamt   = ib - hb;
    assign hist_sh = hist << shamt;

    assign table_index = ((address_bits & imask) ^ hist_sh) & imask;

    // outcome enters at the top of the active history
    always_comb
    begin
        if (hb == '0)
            history_next = '0;
        else
            history_next = ((hist >> 1) | (IDX_W'(taken) << (hb - IB_W'(1)))) & hmask;
    end

endmodule

`default_nettype wire

@@ hdl/gshare_branch_predictor.sv @@
`default_nettype none
// gshare branch predictor, one resolved branch per word, one word per cycle unless stalled
// path: table read into the update stage, then the result word into the output register
// throughput: one word per cycle unless stalled, via table read-modify-write with write forwarding
// reset: history, totals and configuration return to defaults; then a clearing pass
// writes weakly taken into all 2**MAX_INDEX_BITS counters, and no input word is
// accepted until it finishes
module gshare_branch_predictor #(
    parameter int MAX_INDEX_BITS = gshp_pkg::DEF_MAX_INDEX_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gshp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [gshp_pkg::CFG_W-1:0]        cfg_data,
    // resolved branch stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [31:0] branch_address, [32] taken, [39:33] zero
    input  wire logic [gshp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // prediction result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] predicted_taken, [1] mispredicted, [33:2] prediction_count,
    // [65:34] misprediction_count, [71:66] zero
    output logic [gshp_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
    import gshp_pkg::*;

    localparam int IDX_W = MAX_INDEX_BITS;
    localparam int DEPTH = 1 << MAX_INDEX_BITS;

    // configuration registers
    logic [CFG_W-1:0] index_bits_reg;
    logic [CFG_W-1:0] history_bits_reg;

    // clearing pass over the counter table after reset
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    // global history, advanced as each word is accepted (it never needs the counter)
    logic [IDX_W-1:0] history_reg;
    logic [IDX_W-1:0] history_next;
    logic [IDX_W-1:0] hash_idx;

    // counter table
    logic [CTR_W-1:0] table_mem [DEPTH];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [CTR_W-1:0] mem_wdata;

    // update stage: item whose counter was just read
    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_taken_reg;
    logic [CTR_W-1:0] rd_ctr_reg;

    // last counter written, covers a read that raced the write at the same edge
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_idx_reg;
    logic [CTR_W-1:0] fwd_ctr_reg;

    // totals and output register
    logic [COUNT_W-1:0] pred_total_reg;
    logic [COUNT_W-1:0] mis_total_reg;
    logic [COUNT_W-1:0] pred_total_next;
    logic [COUNT_W-1:0] mis_total_next;
    logic               out_valid_reg;
    logic               out_pred_reg;
    logic               out_miss_reg;
    logic [COUNT_W-1:0] out_pred_cnt_reg;
    logic [COUNT_W-1:0] out_mis_cnt_reg;

    logic             in_fire;
    logic             s1_fire;
    logic             cfg_fire;
    logic [CTR_W-1:0] ctr_cur;
    logic [CTR_W-1:0] ctr_new;
    logic             pred;
    logic             miss;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign s1_fire       = s1_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~clearing_reg & (~s1_valid_reg | s1_fire);
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg   <= INDEX_BITS_RST;
            history_bits_reg <= HISTORY_BITS_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_INDEX_BITS:   index_bits_reg   <= cfg_data;
                REG_HISTORY_BITS: history_bits_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // index hash: address bits above bit 1 xor the aligned history
    gshp_index #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_index (
        .index_bits   (index_bits_reg),
        .history_bits (history_bits_reg),
        .address_bits (s_axis_tdata[IDX_W+1:2]),
        .history      (history_reg),
        .taken        (s_axis_tdata[32]),
        .table_index  (hash_idx),
        .history_next (history_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            history_reg <= '0;
        else if (in_fire)
            history_reg <= history_next;
    end

    // clearing pass, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            if (&clr_idx_reg)
                clearing_reg <= 1'b0;
        end
    end

    // counter lookup and saturating update
    assign ctr_cur = (fwd_valid_reg && fwd_idx_reg == s1_idx_reg) ? fwd_ctr_reg : rd_ctr_reg;
    assign pred    = ctr_cur >= CTR_WEAK_TAKEN;
    assign miss    = pred ^ s1_taken_reg;

    always_comb
    begin
        ctr_new = ctr_cur;
        if (s1_taken_reg)
        begin
            if (ctr_cur != CTR_STRONG_TKN)
                ctr_new = ctr_cur + CTR_W'(1);
        end
        else
        begin
            if (ctr_cur != CTR_STRONG_NT)
                ctr_new = ctr_cur - CTR_W'(1);
        end
    end

    // table write port is shared between the clearing pass and updates
    assign mem_we    = clearing_reg | s1_fire;
    assign mem_waddr = clearing_reg ? clr_idx_reg : s1_idx_reg;
    assign mem_wdata = clearing_reg ? CTR_WEAK_TAKEN : ctr_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        if (in_fire)
            rd_ctr_reg <= table_mem[hash_idx];
    end

    // update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_idx_reg   <= hash_idx;
            s1_taken_reg <= s_axis_tdata[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (s1_fire)
            fwd_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_ctr_reg <= ctr_new;
        end
    end

    // saturating totals
    assign pred_total_next = (&pred_total_reg) ? pred_total_reg
                                               : pred_total_reg + COUNT_W'(1);
    assign mis_total_next  = (!miss || &mis_total_reg) ? mis_total_reg
                                                       : mis_total_reg + COUNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_total_reg <= '0;
            mis_total_reg  <= '0;
        end
        else if (s1_fire)
        begin
            pred_total_reg <= pred_total_next;
            mis_total_reg  <= mis_total_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_pred_reg     <= pred;
            out_miss_reg     <= miss;
            out_pred_cnt_reg <= pred_total_next;
            out_mis_cnt_reg  <= mis_total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_mis_cnt_reg, out_pred_cnt_reg, out_miss_reg, out_pred_reg};

    // no branch enters while the table is being cleared
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s_axis_tready)
        else $error("input accepted during table clear");

    // an accepted word always reaches the update stage
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted word lost before update");

    // mispredictions never outnumber predictions
    a_totals_order: assert property (@(posedge clk) disable iff (!rst_n)
        mis_total_reg <= pred_total_reg)
        else $error("misprediction total above prediction total");

    // every update leaves a nonzero prediction total
    a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> pred_total_reg != '0)
        else $error("prediction total did not advance");

endmodule

`default_nettype wire

@@ tb/gshare_branch_predictor_tb.sv @@
`default_nettype none

module gshare_branch_predictor_tb;

    import gshp_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int TABLE_BITS    = DEF_MAX_INDEX_BITS;
    localparam int TABLE_DEPTH   = 1 << TABLE_BITS;
    localparam int MAX_GAP       = 6;
    localparam int LONG_STALL    = 300;
    localparam int SETTLE_CYCLES = 8;
    // the clearing pass after reset is the longest quiet stretch of a good run
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 20;
    localparam int NUM_ROWS        = 30;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 77;
    localparam int POOL_SIZE       = 8;

    // indexes past the two registers, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    // one result word, laid out as on m_axis_tdata[65:0]
    typedef struct packed {
        bit [COUNT_W-1:0] mispredictions;
        bit [COUNT_W-1:0] predictions;
        bit               mispredicted;
        bit               predicted_taken;
    } outcome_t;

    typedef enum bit {ROW_BRANCH, ROW_SETUP} row_kind_t;

    // directed row: a branch word, or a new predictor setting
    typedef struct packed {
        row_kind_t  kind;
        bit [31:0]  addr;
        bit         taken;
        bit [3:0]   ib;
        bit [3:0]   hb;
        bit         known;
        bit         known_pred;
        bit         known_miss;
    } stim_row_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    // predictor state kept by the bench
    bit [CTR_W-1:0]   ctr_table [TABLE_DEPTH];
    int unsigned      ghr           = 0;
    bit [COUNT_W-1:0] pred_total    = '0;
    bit [COUNT_W-1:0] miss_total    = '0;
    bit [CFG_W-1:0]   idx_bits_reg  = INDEX_BITS_RST;
    bit [CFG_W-1:0]   hist_bits_reg = HISTORY_BITS_RST;

    outcome_t    pending_outcomes [$];
    stim_row_t   stim_rows [NUM_ROWS];
    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned branches_sent   = 0;
    int unsigned settings_used   = 0;
    bit          idle_on         = 1'b1;
    bit          stall_request   = 1'b0;

    gshare_branch_predictor u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // gshare index, counter lookup and update, history shift, saturating totals
    function automatic outcome_t predict_outcome(input bit [31:0] addr, input bit tk);
        outcome_t       o;
        int unsigned    ib;
        int unsigned    hb;
        int unsigned    hmask;
        int unsigned    imask;
        int unsigned    hist;
        int unsigned    idx;
        bit [CTR_W-1:0] ctr;
        ib = idx_bits_reg;
        if (ib < 1)
            ib = 1;
        if (ib > TABLE_BITS)
            ib = TABLE_BITS;
        hb = (hist_bits_reg > ib) ? ib : hist_bits_reg;
        hmask = (32'd1 << hb) - 32'd1;
        imask = (32'd1 << ib) - 32'd1;
        hist = ghr & hmask;
        idx = (((addr >> 2) & imask) ^ (hist << (ib - hb))) & imask;
        ctr = ctr_table[idx];
        o.predicted_taken = (ctr >= CTR_WEAK_TAKEN);
        o.mispredicted = (o.predicted_taken != tk);
        if (tk && ctr != CTR_STRONG_TKN)
            ctr = ctr + 1'b1;
        else if (!tk && ctr != CTR_STRONG_NT)
            ctr = ctr - 1'b1;
        ctr_table[idx] = ctr;
        // outcome enters at the top of the active history length
        if (hb > 0)
            ghr = ((hist >> 1) | (32'(tk) << (hb - 1))) & hmask;
        else
            ghr = 0;
        if (pred_total != '1)
            pred_total = pred_total + 1'b1;
        if (o.mispredicted && miss_total != '1)
            miss_total = miss_total + 1'b1;
        o.predictions = pred_total;
        o.mispredictions = miss_total;
        return o;
    endfunction

    function automatic stim_row_t br_known(input bit [31:0] addr, input bit tk,
                                           input bit p, input bit m);
        return '{ROW_BRANCH, addr, tk, 4'd0, 4'd0, 1'b1, p, m};
    endfunction

    function automatic stim_row_t br_row(input bit [31:0] addr, input bit tk);
        return '{ROW_BRANCH, addr, tk, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0};
    endfunction

    function automatic stim_row_t setup_row(input bit [3:0] ib, input bit [3:0] hb);
        return '{ROW_SETUP, 32'd0, 1'b0, ib, hb, 1'b0, 1'b0, 1'b0};
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    // leaves cfg_valid high so back-to-back writes follow without a gap
    task automatic cfg_write(input bit [CFG_INDEX_W-1:0] idx, input bit [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_INDEX_BITS)
            idx_bits_reg = val;
        else if (idx == REG_HISTORY_BITS)
            hist_bits_reg = val;
    endtask

    // new setting once the block has drained; spare index goes last to catch aliasing
    task automatic apply_setting(input bit [3:0] ib, input bit [3:0] hb);
        s_axis_tvalid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        cfg_write(REG_INDEX_BITS, ib);
        cfg_write(REG_HISTORY_BITS, hb);
        cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_W'($urandom_range(0, 15)));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // tvalid stays high on return, the caller lowers it when the stream pauses
    task automatic send_branch(input bit [31:0] addr, input bit tk, input bit known,
                               input bit known_pred, input bit known_miss);
        int unsigned gap;
        outcome_t    want;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({tk, addr});
        do @(posedge clk); while (!s_axis_tready);
        want = predict_outcome(addr, tk);
        if (known)
        begin
            want.predicted_taken = known_pred;
            want.mispredicted = known_miss;
        end
        pending_outcomes.push_back(want);
        branches_sent++;
    endtask

    // result side: random hold-off per word, one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold;
        forever
        begin
            hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall_request)
            begin
                hold = LONG_STALL;
                stall_request = 1'b0;
            end
            if (hold != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // compare every accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(outcome_t)-1:0];
            if (pending_outcomes.size() == 0)
                report_mismatch("result word with nothing expected", 64'd0,
                                64'(got.predictions));
            else
            begin
                want = pending_outcomes.pop_front();
                results_checked++;
                if (got.predicted_taken != want.predicted_taken)
                    report_mismatch("predicted_taken", 64'(want.predicted_taken),
                                    64'(got.predicted_taken));
                if (got.mispredicted != want.mispredicted)
                    report_mismatch("mispredicted", 64'(want.mispredicted),
                                    64'(got.mispredicted));
                if (got.predictions != want.predictions)
                    report_mismatch("prediction_count", 64'(want.predictions),
                                    64'(got.predictions));
                if (got.mispredictions != want.mispredictions)
                    report_mismatch("misprediction_count", 64'(want.mispredictions),
                                    64'(got.mispredictions));
            end
        end
    end

    // ends the run when no word moves on any channel for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        bit [31:0]   addr_pool [POOL_SIZE];
        int unsigned trip_len [POOL_SIZE];
        int unsigned trip_pos [POOL_SIZE];
        int unsigned pick;
        int unsigned k;
        bit [31:0]   addr;
        bit          tk;
        bit [3:0]    ib;
        bit [3:0]    hb;

        foreach (ctr_table[i])
            ctr_table[i] = CTR_WEAK_TAKEN;

        // first block runs on the reset setting: 12 index bits, bimodal
        stim_rows = '{
            br_known(32'h0000_0000, 1'b1, 1'b1, 1'b0),  // weakly taken after reset
            br_known(32'h0000_0000, 1'b0, 1'b1, 1'b1),
            br_known(32'h0000_0000, 1'b0, 1'b1, 1'b1),
            br_known(32'h0000_0000, 1'b0, 1'b0, 1'b0),
            br_known(32'h0000_0000, 1'b0, 1'b0, 1'b0),  // stays strongly not taken
            br_known(32'h0000_0000, 1'b1, 1'b0, 1'b1),
            br_known(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1),  // top table entry
            br_known(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1),
            br_known(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0),
            br_known(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0),  // stays strongly taken
            br_known(32'h0000_0003, 1'b1, 1'b0, 1'b1),  // byte offset bits ignored
            br_known(32'h0000_4000, 1'b0, 1'b1, 1'b1),  // address bit above the index
            br_known(32'h0000_0004, 1'b1, 1'b1, 1'b0),
            setup_row(4'd4, 4'd4),                      // history as long as index
            br_row(32'h0000_0010, 1'b1),
            br_row(32'h0000_0010, 1'b1),
            br_row(32'h0000_0010, 1'b0),
            br_row(32'h0000_0020, 1'b1),
            br_row(32'h0000_0010, 1'b0),
            setup_row(4'd3, 4'd15),                     // history clamped to index width
            br_row(32'h0000_0008, 1'b1),
            br_row(32'h0000_0008, 1'b1),
            br_row(32'h0000_000C, 1'b0),
            setup_row(4'd0, 4'd2),                      // zero index width acts as one
            br_row(32'h0000_0004, 1'b1),
            br_row(32'h0000_0000, 1'b0),
            br_row(32'h0000_0004, 1'b1),
            setup_row(4'd15, 4'd12),                    // index width above the table
            br_row(32'hFFFF_FFFC, 1'b0),
            br_row(32'h0000_0000, 1'b1)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (stim_rows[i].kind == ROW_SETUP)
                apply_setting(stim_rows[i].ib, stim_rows[i].hb);
            else
                send_branch(stim_rows[i].addr, stim_rows[i].taken, stim_rows[i].known,
                            stim_rows[i].known_pred, stim_rows[i].known_miss);
        end

        // random phases: extremes first, then random settings; table and history carry over
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin ib = 4'd1;  hb = 4'd0;  end
                1: begin ib = 4'd1;  hb = 4'd1;  end
                2: begin ib = 4'd12; hb = 4'd12; end
                3: begin ib = 4'd15; hb = 4'd15; end
                4: begin ib = 4'd0;  hb = 4'd0;  end
                5: begin ib = 4'd12; hb = 4'd0;  end
                default:
                begin
                    ib = 4'($urandom_range(0, 15));
                    hb = 4'($urandom_range(0, 15));
                end
            endcase
            apply_setting(ib, hb);

            // some phases run without gaps; in one the sink stalls long against a full input
            idle_on = (ph % 4 != 1) && (ph != 3);
            if (ph == 3)
                stall_request = 1'b1;

            // a few hot branches with loop-like outcome patterns train the counters
            for (int j = 0; j < POOL_SIZE; j++)
            begin
                addr_pool[j] = $urandom;
                trip_len[j] = $urandom_range(1, 6);
                trip_pos[j] = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 9);
                k = $urandom_range(0, POOL_SIZE - 1);
                if (pick < 7)
                begin
                    addr = addr_pool[k];
                    tk = (trip_pos[k] % trip_len[k]) != trip_len[k] - 1;
                    trip_pos[k]++;
                end
                else if (pick < 9)
                begin
                    addr = addr_pool[k];
                    tk = ($urandom_range(0, 3) != 0);
                end
                else
                begin
                    addr = $urandom;
                    tk = 1'($urandom_range(0, 1));
                end
                send_branch(addr, tk, 1'b0, 1'b0, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d branch words under %0d predictor settings, incl. a %0d-cycle stall",
                 branches_sent, settings_used, LONG_STALL);
        $display("compared %0d result words; %0d mispredictions counted",
                 results_checked, miss_total);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
